/* rtl/pq_pkg.sv */
// Package: beat types, status and mode codes, and ring control structs for the priority queue.
package pq_pkg;

  localparam int CodeBits  = 32;
  localparam int CountBits = 6;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                mode;
    logic                is_priority;
    logic [CodeBits-1:0] code_in;
  } req_t;

  typedef struct packed {
    logic [CodeBits-1:0]  code_out;
    logic                 from_priority;
    logic [1:0]           status;
    logic [CountBits-1:0] total_count;
  } rsp_t;

  // Per-class ring commands, issued by the top level.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_req_t;

  // Per-class ring occupancy flags.
  typedef struct packed {
    logic full;
    logic nonempty;
  } ring_flags_t;

endpackage

/* rtl/two_class_priority_queue_core.sv */
// Top level: two-class strict-priority queue with one result beat per request beat.
//
//   channel | direction | payload       | handshake
//   req     | in        | pq_pkg::req_t | req_valid / req_ready
//   rsp     | out       | pq_pkg::rsp_t | rsp_valid / rsp_ready
//
// One request beat per cycle while req_ready is high; its result beat is valid the cycle after acceptance.
// The decision, pointer and count updates all settle at the accepting edge; the popped
// code comes out of the class store's registered read port at that same edge.
// Synchronous reset empties both classes; store contents are left as they are.
// req_ready drops only while a result beat waits and rsp_ready is low.
module two_class_priority_queue_core #(
  parameter int CLASS_DEPTH = 16,
  parameter int CODE_WIDTH  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  pq_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output pq_pkg::rsp_t rsp
);

  localparam int CW = $clog2(CLASS_DEPTH + 1);
  localparam int TW = CW + 1;

  logic                accept;
  logic                is_enq;
  logic                is_deq;
  pq_pkg::ring_req_t   p_req;
  pq_pkg::ring_req_t   r_req;
  pq_pkg::ring_flags_t p_flags;
  pq_pkg::ring_flags_t r_flags;
  logic [CW-1:0]       p_count;
  logic [CW-1:0]       r_count;
  logic [CODE_WIDTH-1:0] p_rdata;
  logic [CODE_WIDTH-1:0] r_rdata;
  logic [CODE_WIDTH-1:0] code_store;
  logic [TW-1:0]       total_after;
  logic [1:0]          status_next;

  // Result register (control part; the code sits in the stores' read registers).
  logic                               popped;
  logic                               from_priority;
  logic [1:0]                         status;
  logic [pq_pkg::CountBits-1:0]       total_count;

  // Ready whenever the result register is free or being emptied this cycle.
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign is_enq = (req.mode == pq_pkg::MODE_ENQUEUE);
  assign is_deq = (req.mode == pq_pkg::MODE_DEQUEUE);

  // Strict priority: the priority class is served first on a dequeue.
  assign p_req.push = accept && is_enq && req.is_priority && !p_flags.full;
  assign r_req.push = accept && is_enq && !req.is_priority && !r_flags.full;
  assign p_req.pop  = accept && is_deq && p_flags.nonempty;
  assign r_req.pop  = accept && is_deq && !p_flags.nonempty && r_flags.nonempty;

  assign code_store = CODE_WIDTH'(req.code_in);

  // Occupancy after the operation; reported modulo 64.
  always_comb begin
    total_after = TW'(p_count) + TW'(r_count);
    if (p_req.push || r_req.push) begin
      total_after = total_after + TW'(1);
    end else if (p_req.pop || r_req.pop) begin
      total_after = total_after - TW'(1);
    end
  end

  always_comb begin
    status_next = pq_pkg::STATUS_OK;
    if (is_enq && !(p_req.push || r_req.push)) begin
      status_next = pq_pkg::STATUS_FULL;
    end else if (is_deq && !(p_req.pop || r_req.pop)) begin
      status_next = pq_pkg::STATUS_EMPTY;
    end
  end

  pq_ring #(
    .DEPTH (CLASS_DEPTH),
    .WIDTH (CODE_WIDTH)
  ) u_prio_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (p_req),
    .wdata (code_store),
    .rdata (p_rdata),
    .count (p_count),
    .flags (p_flags)
  );

  pq_ring #(
    .DEPTH (CLASS_DEPTH),
    .WIDTH (CODE_WIDTH)
  ) u_reg_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (r_req),
    .wdata (code_store),
    .rdata (r_rdata),
    .count (r_count),
    .flags (r_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped        <= p_req.pop || r_req.pop;
      from_priority <= p_req.pop;
      status        <= status_next;
      total_count   <= pq_pkg::CountBits'(total_after);
    end
  end

  // Code is zero unless a beat was actually dequeued.
  always_comb begin
    rsp.code_out      = '0;
    if (popped) begin
      rsp.code_out = from_priority ? pq_pkg::CodeBits'(p_rdata)
                                   : pq_pkg::CodeBits'(r_rdata);
    end
    rsp.from_priority = from_priority;
    rsp.status        = status;
    rsp.total_count   = total_count;
  end

endmodule

/* rtl/pq_ring.sv */
// One class of the queue: ring store, read and write pointers, and occupancy count.
module pq_ring #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pq_pkg::ring_req_t          req,
  input  logic [WIDTH-1:0]           wdata,
  output logic [WIDTH-1:0]           rdata,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output pq_pkg::ring_flags_t        flags
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr_next;
  logic [AW-1:0]    wr_ptr_next;
  logic [CW-1:0]    count_next;

  assign rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
  assign wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);

  always_comb begin
    count_next = count;
    if (req.push && !req.pop) begin
      count_next = count + CW'(1);
    end else if (req.pop && !req.push) begin
      count_next = count - CW'(1);
    end
  end

  assign flags.full     = (count == CW'(DEPTH));
  assign flags.nonempty = (count != '0);

  // Store: one write port, one registered read port at the head.
  always_ff @(posedge clk) begin
    if (req.push) begin
      store[wr_ptr] <= wdata;
    end
    if (req.pop) begin
      rdata <= store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (req.push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (req.pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count_next;
    end
  end

endmodule

/* dv/two_class_priority_queue_core_tb.sv */
// Testbench for the two-class priority queue: directed table, then randomised phases vs predictor.
module two_class_priority_queue_core_tb;

  localparam int CLASS_DEPTH  = 16;
  localparam int RANDOM_BEATS = 950;
  localparam int QUIET_FROM   = 850;
  localparam int LONG_HOLD    = 80;
  localparam int STALL_LIMIT  = 2000;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         req_valid = 1'b0;
  logic         req_ready;
  pq_pkg::req_t req       = '0;
  logic         rsp_valid;
  logic         rsp_ready = 1'b0;
  pq_pkg::rsp_t rsp;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_class_priority_queue_core #(
    .CLASS_DEPTH(CLASS_DEPTH),
    .CODE_WIDTH (pq_pkg::CodeBits)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Predictor state: one FIFO of codes per class
  logic [pq_pkg::CodeBits-1:0] prio_codes[$];
  logic [pq_pkg::CodeBits-1:0] reg_codes[$];
  pq_pkg::rsp_t                awaited_rsp[$];
  int                          mismatch_cnt = 0;

  // Side band from the sender: a typed-in result for the beat on offer
  bit           cur_typed = 1'b0;
  pq_pkg::rsp_t cur_want  = '0;
  bit           hold_rx   = 1'b0;
  bit           quiet     = 1'b0;

  typedef struct {
    pq_pkg::req_t stim;
    bit           typed;
    pq_pkg::rsp_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic pq_pkg::rsp_t strict_priority_step(input pq_pkg::req_t r);
    pq_pkg::rsp_t o;
    o = '0;
    if (r.mode == pq_pkg::MODE_ENQUEUE) begin
      if (r.is_priority) begin
        if (prio_codes.size() >= CLASS_DEPTH) o.status = pq_pkg::STATUS_FULL;
        else prio_codes.push_back(r.code_in);
      end else begin
        if (reg_codes.size() >= CLASS_DEPTH) o.status = pq_pkg::STATUS_FULL;
        else reg_codes.push_back(r.code_in);
      end
    end else if (prio_codes.size() > 0) begin
      o.code_out      = prio_codes.pop_front();
      o.from_priority = 1'b1;
    end else if (reg_codes.size() > 0) begin
      o.code_out = reg_codes.pop_front();
    end else begin
      o.status = pq_pkg::STATUS_EMPTY;
    end
    o.total_count = pq_pkg::CountBits'(prio_codes.size() + reg_codes.size());
    return o;
  endfunction

  function automatic void add_row(input logic mode, input logic prio,
                                  input logic [pq_pkg::CodeBits-1:0] code,
                                  input bit typed = 1'b0,
                                  input logic [pq_pkg::CodeBits-1:0] w_code = '0,
                                  input logic w_from = 1'b0,
                                  input logic [1:0] w_status = pq_pkg::STATUS_OK,
                                  input logic [pq_pkg::CountBits-1:0] w_count = '0);
    stim_row_t row;
    row.stim.mode               = mode;
    row.stim.is_priority        = prio;
    row.stim.code_in            = code;
    row.typed                   = typed;
    row.want.code_out           = w_code;
    row.want.from_priority      = w_from;
    row.want.status             = w_status;
    row.want.total_count        = w_count;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [pq_pkg::CodeBits-1:0] pick_code();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic compare_beat(input pq_pkg::rsp_t want, input pq_pkg::rsp_t got);
    if (got.code_out !== want.code_out) begin
      $display("%0t code_out: expected %h, actual %h", $time, want.code_out, got.code_out);
      mismatch_cnt++;
    end
    if (got.from_priority !== want.from_priority) begin
      $display("%0t from_priority: expected %b, actual %b", $time,
               want.from_priority, got.from_priority);
      mismatch_cnt++;
    end
    if (got.status !== want.status) begin
      $display("%0t status: expected %0d, actual %0d", $time, want.status, got.status);
      mismatch_cnt++;
    end
    if (got.total_count !== want.total_count) begin
      $display("%0t total_count: expected %0d, actual %0d", $time,
               want.total_count, got.total_count);
      mismatch_cnt++;
    end
  endtask

  // Request beats are predicted before result beats are checked, so a
  // same-edge result would still find its expectation.
  always @(posedge clk) begin
    pq_pkg::rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        want = strict_priority_step(req);
        if (cur_typed) want = cur_want;
        awaited_rsp.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t unexpected result beat: expected none, actual %h", $time, rsp);
          mismatch_cnt++;
        end else begin
          compare_beat(awaited_rsp.pop_front(), rsp);
        end
      end
    end
  end

  task automatic send_beat(input pq_pkg::req_t r, input bit typed, input pq_pkg::rsp_t want);
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= r;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic idle_tx(input int n);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Sink: random ready bursts, one long hold on request, steady at the end
  initial begin
    int   n;
    logic lvl;
    wait (!rst);
    forever begin
      if (hold_rx) begin
        lvl     = 1'b0;
        n       = LONG_HOLD;
        hold_rx = 1'b0;
      end else if (quiet) begin
        lvl = 1'b1;
        n   = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        lvl = 1'b0;
        n   = $urandom_range(1, 19);
      end else begin
        lvl = 1'b1;
        n   = $urandom_range(1, 40);
      end
      @(negedge clk);
      rsp_ready <= lvl;
      repeat (n - 1) @(negedge clk);
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin
    int stall;
    stall = 0;
    do begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall = 0;
      else stall++;
    end while (stall < STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    pq_pkg::req_t r;
    int           sent;
    int           phase;
    int           len;
    int           enq_pct;
    int           prio_pct;
    sent  = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty queue, both extremes of code, class order, then priority class overflow
    add_row(pq_pkg::MODE_DEQUEUE, 1'b0, '0, 1'b1, '0, 1'b0, pq_pkg::STATUS_EMPTY, 6'd0);
    add_row(pq_pkg::MODE_ENQUEUE, 1'b0, '0, 1'b1, '0, 1'b0, pq_pkg::STATUS_OK, 6'd1);
    add_row(pq_pkg::MODE_ENQUEUE, 1'b1, '1, 1'b1, '0, 1'b0, pq_pkg::STATUS_OK, 6'd2);
    add_row(pq_pkg::MODE_DEQUEUE, 1'b0, '0, 1'b1, '1, 1'b1, pq_pkg::STATUS_OK, 6'd1);
    add_row(pq_pkg::MODE_DEQUEUE, 1'b0, '0, 1'b1, '0, 1'b0, pq_pkg::STATUS_OK, 6'd0);
    add_row(pq_pkg::MODE_DEQUEUE, 1'b1, '1, 1'b1, '0, 1'b0, pq_pkg::STATUS_EMPTY, 6'd0);
    for (int i = 0; i < CLASS_DEPTH; i++) begin
      add_row(pq_pkg::MODE_ENQUEUE, 1'b1, 32'hA5A5_0000 + i);
    end
    add_row(pq_pkg::MODE_ENQUEUE, 1'b1, 32'h5A5A_FFFF, 1'b1, '0, 1'b0,
            pq_pkg::STATUS_FULL, 6'd16);
    add_row(pq_pkg::MODE_DEQUEUE, 1'b0, '0);
    add_row(pq_pkg::MODE_ENQUEUE, 1'b0, 32'h0000_0001);

    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 5) == 0) idle_tx($urandom_range(1, 19));
      send_beat(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    // Phases lean towards filling, draining or a mix, with a skewed class choice
    while (sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      case ($urandom_range(0, 3))
        0:       prio_pct = 0;
        1:       prio_pct = 100;
        default: prio_pct = $urandom_range(0, 100);
      endcase
      len = $urandom_range(20, 60);
      if (phase == 2 || phase == 7) begin
        @(negedge clk);
        req_valid <= 1'b0;
        wait (awaited_rsp.size() == 0);
      end
      if (phase == 3) hold_rx = 1'b1;
      for (int k = 0; k < len && sent < RANDOM_BEATS; k++) begin
        quiet = (sent >= QUIET_FROM);
        if (!quiet && phase != 3 && $urandom_range(0, 5) == 0) idle_tx($urandom_range(1, 19));
        r.mode        = ($urandom_range(1, 100) <= enq_pct) ? pq_pkg::MODE_ENQUEUE
                                                             : pq_pkg::MODE_DEQUEUE;
        r.is_priority = ($urandom_range(1, 100) <= prio_pct);
        r.code_in     = pick_code();
        send_beat(r, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    @(negedge clk);
    req_valid <= 1'b0;
    wait (awaited_rsp.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pq_pkg.sv
rtl/pq_ring.sv
rtl/two_class_priority_queue_core.sv
dv/two_class_priority_queue_core_tb.sv
